// ===== sv/wlkp_pkg.sv =====
// Shared types, constants and the ticket table of the weighted lottery key picker.
// Used by the top level core; the interfaces and the generic RAM do not import it.
package wlkp_pkg;

	// Sizing of the block
	localparam int SLOT_COUNT  = 16;
	localparam int TIME_BITS   = 48;
	localparam int WEIGHT_MAX  = 100;
	localparam int KEY_COUNT   = 256;
	localparam int KEY_BITS    = 8;
	localparam int WEIGHT_BITS = 7;
	localparam int GAP_BITS    = 16;
	localparam int RANDOM_BITS = 32;
	localparam int TICKET_BITS = 7;

	localparam int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_BITS    = $clog2(SLOT_COUNT + 1);
	localparam int TOTAL_BITS  = $clog2(SLOT_COUNT * WEIGHT_MAX + 1);

	// Command codes carried by an item
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAW,
		ST_PICK,
		ST_EMIT
	} state_t;

	// One action slot
	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [WEIGHT_BITS-1:0] weight;
		logic [GAP_BITS-1:0]    gap;
		logic                   enabled;
		logic                   keyboard;
	} slot_t;

	typedef logic [(1 << WEIGHT_BITS)-1:0][TICKET_BITS-1:0] ticket_lut_t;

	// Tickets per weight: max(1, w*w/100), weight clamped to the maximum
	function automatic ticket_lut_t build_ticket_lut();
		ticket_lut_t lut;
		int w;
		int sq;
		for (int i = 0; i < (1 << WEIGHT_BITS); i++) begin
			w = (i > WEIGHT_MAX) ? WEIGHT_MAX : i;
			sq = (w * w) / WEIGHT_MAX;
			lut[i] = (sq < 1) ? TICKET_BITS'(1) : TICKET_BITS'(sq);
		end
		return lut;
	endfunction

	localparam ticket_lut_t TICKET_LUT = build_ticket_lut();

endpackage

// ===== sv/wlkp_if.sv =====
// Valid/ready channel interfaces of the weighted lottery key picker.
// Standalone: plain payload fields, no package needed.
interface wlkp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  slot_index;
	logic [7:0]  entry_key;
	logic [6:0]  entry_weight;
	logic [15:0] entry_gap_ms;
	logic        entry_enabled;
	logic        entry_is_keyboard;
	logic [47:0] now_ms;
	logic [31:0] random_word;

	modport source (
		output valid, cmd, slot_index, entry_key, entry_weight, entry_gap_ms,
		       entry_enabled, entry_is_keyboard, now_ms, random_word,
		input  ready
	);
	modport sink (
		input  valid, cmd, slot_index, entry_key, entry_weight, entry_gap_ms,
		       entry_enabled, entry_is_keyboard, now_ms, random_word,
		output ready
	);
endinterface

interface wlkp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] chosen_key;
	logic       by_fallback;

	modport source (output valid, chosen_key, by_fallback, input ready);
	modport sink   (input valid, chosen_key, by_fallback, output ready);
endinterface

// ===== sv/weighted_lottery_key_picker_core.sv =====
// Weighted lottery key picker: picks at most one key per tick from a table of action slots.
// Depends on wlkp_pkg, the wlkp_req_if/wlkp_rsp_if interfaces and wlkp_ram.
//
// Load, start and stop items take one cycle, and so does a tick while stopped.
// A tick while running passes through these steps in order: the accept, a scan of
// every slot through the press-time RAM lookup and ticket adder and the drain
// of that pipeline, the draw multiply, then a walk over the slots through the
// ticket compare-subtract unit until the drawn ticket is hit (none on a
// fallback), and the posting of the result (a key of zero is not posted). The
// request side is not ready during a tick. A finished result waits in an output
// register; the next item is taken meanwhile, and a later result waits for that
// register to drain. Press times live in a 256-entry RAM; per-key seen bits are
// flip-flops cleared at once.
module weighted_lottery_key_picker_core
	import wlkp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	wlkp_req_if.sink      req,
	wlkp_rsp_if.source    rsp
);

	state_t state_q, state_d;

	logic                  running_q;
	slot_t                 slots_q [SLOT_COUNT];
	logic [KEY_COUNT-1:0]  press_seen_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [RANDOM_BITS-1:0] random_q;

	logic [CNT_BITS-1:0]   cnt_q;
	logic [SLOT_BITS-1:0]  cnt_idx;
	logic                  vld_s1;
	logic [SLOT_BITS-1:0]  idx_s1;
	slot_t                 slot_s1;

	logic [TICKET_BITS-1:0] tk_q [SLOT_COUNT];
	logic [TOTAL_BITS-1:0]  total_q;
	logic [WEIGHT_BITS-1:0] best_w_q;
	logic [KEY_BITS-1:0]    best_key_q;
	logic [TOTAL_BITS-1:0]  pick_q;
	logic [KEY_BITS-1:0]    key_q;
	logic                   fb_q;

	logic                   out_valid_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic                   out_fb_q;

	logic                   accept;
	cmd_t                   cmd;
	logic                   issue;
	logic                   emit_go;
	logic                   hit;
	logic                   last;
	logic [TIME_BITS-1:0]   last_time;
	logic [TIME_BITS-1:0]   delta;
	logic                   cool_ok;
	logic [TICKET_BITS-1:0] tk_s1;
	logic [RANDOM_BITS+TOTAL_BITS-1:0] prod;
	logic [WEIGHT_BITS-1:0] load_w;

	assign cmd     = cmd_t'(req.cmd);
	assign cnt_idx = cnt_q[SLOT_BITS-1:0];
	assign load_w  = (req.entry_weight > WEIGHT_BITS'(WEIGHT_MAX))
		? WEIGHT_BITS'(WEIGHT_MAX) : req.entry_weight;

	// Press-time RAM: read at the key of the issued slot, write on a press
	wlkp_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (KEY_COUNT)
	) u_press_ram (
		.clk   (clk),
		.we    (emit_go),
		.waddr (key_q),
		.wdata (now_q),
		.raddr (slots_q[cnt_idx].key),
		.rdata (last_time)
	);

	// Evaluate the slot in stage 1: cooldown check and ticket lookup
	always_comb begin
		delta   = now_q - last_time;
		cool_ok = !press_seen_q[slot_s1.key]
			|| ((now_q >= last_time) && (delta >= TIME_BITS'(slot_s1.gap)));
		tk_s1   = (slot_s1.enabled && slot_s1.keyboard && cool_ok)
			? TICKET_LUT[slot_s1.weight] : '0;
	end

	// Draw multiply and ticket walk compare
	assign prod = (RANDOM_BITS + TOTAL_BITS)'(random_q)
		* (RANDOM_BITS + TOTAL_BITS)'(total_q);
	assign hit  = pick_q < TOTAL_BITS'(tk_q[cnt_idx]);
	assign last = cnt_q == CNT_BITS'(SLOT_COUNT - 1);

	// Next state and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == ST_IDLE);
		accept    = req.valid && req.ready;
		issue     = (state_q == ST_SCAN) && (cnt_q < CNT_BITS'(SLOT_COUNT));
		emit_go   = (state_q == ST_EMIT) && (key_q != '0)
			&& (!out_valid_q || rsp.ready);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_TICK) && running_q) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				state_d = (total_q == '0) ? ST_EMIT : ST_PICK;
			end
			ST_PICK: begin
				if (hit || last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if ((key_q == '0) || emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: run flag, slot table, seen bits, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			press_seen_q <= '0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= '0;
			end
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (accept) begin
				cnt_q <= '0;
				unique case (cmd)
					CMD_LOAD: begin
						if (!running_q && (32'(req.slot_index) < SLOT_COUNT)) begin
							slots_q[SLOT_BITS'(req.slot_index)] <= '{
								key:      req.entry_key,
								weight:   load_w,
								gap:      req.entry_gap_ms,
								enabled:  req.entry_enabled,
								keyboard: req.entry_is_keyboard
							};
						end
					end
					CMD_START: begin
						press_seen_q <= '0;
						running_q    <= 1'b1;
					end
					CMD_STOP: begin
						press_seen_q <= '0;
						running_q    <= 1'b0;
					end
					CMD_TICK: begin
					end
				endcase
			end
			if (state_q == ST_DRAW) begin
				cnt_q <= '0;
			end
			if ((state_q == ST_PICK) && !hit) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (emit_go) begin
				press_seen_q[key_q] <= 1'b1;
			end
		end
	end

	// Payload: tick operands, scan pipeline, totals, draw and result
	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_TICK)) begin
			now_q      <= TIME_BITS'(req.now_ms);
			random_q   <= req.random_word;
			total_q    <= '0;
			best_w_q   <= '0;
			best_key_q <= '0;
		end
		if (issue) begin
			slot_s1 <= slots_q[cnt_idx];
			idx_s1  <= cnt_idx;
		end
		if (vld_s1) begin
			tk_q[idx_s1] <= tk_s1;
			total_q      <= total_q + TOTAL_BITS'(tk_s1);
			if (slot_s1.enabled && slot_s1.keyboard && (slot_s1.weight > best_w_q)) begin
				best_w_q   <= slot_s1.weight;
				best_key_q <= slot_s1.key;
			end
		end
		if (state_q == ST_DRAW) begin
			pick_q <= prod[RANDOM_BITS +: TOTAL_BITS];
			if (total_q == '0) begin
				key_q <= best_key_q;
				fb_q  <= 1'b1;
			end else begin
				key_q <= '0;
				fb_q  <= 1'b0;
			end
		end
		if (state_q == ST_PICK) begin
			if (hit) begin
				key_q <= slots_q[cnt_idx].key;
			end else begin
				pick_q <= pick_q - TOTAL_BITS'(tk_q[cnt_idx]);
			end
		end
		if (emit_go) begin
			out_key_q <= key_q;
			out_fb_q  <= fb_q;
		end
	end

	// Drive the result channel
	assign rsp.valid       = out_valid_q;
	assign rsp.chosen_key  = out_key_q;
	assign rsp.by_fallback = out_fb_q;

endmodule

// ===== sv/wlkp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module wlkp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
